// ===== rtl/core/bcpu_pkg.sv =====
// ----------------------------------------------------------------------------
// bcpu_pkg
// Shared types and operation codes for the byte CPU execute unit.
// ----------------------------------------------------------------------------
package bcpu_pkg;

  localparam logic [5:0] OP_LDA = 6'd0;
  localparam logic [5:0] OP_LDX = 6'd1;
  localparam logic [5:0] OP_LDY = 6'd2;
  localparam logic [5:0] OP_STA = 6'd3;
  localparam logic [5:0] OP_STX = 6'd4;
  localparam logic [5:0] OP_STY = 6'd5;
  localparam logic [5:0] OP_TAX = 6'd6;
  localparam logic [5:0] OP_TAY = 6'd7;
  localparam logic [5:0] OP_TXA = 6'd8;
  localparam logic [5:0] OP_TYA = 6'd9;
  localparam logic [5:0] OP_TSX = 6'd10;
  localparam logic [5:0] OP_TXS = 6'd11;
  localparam logic [5:0] OP_INX = 6'd12;
  localparam logic [5:0] OP_INY = 6'd13;
  localparam logic [5:0] OP_DEX = 6'd14;
  localparam logic [5:0] OP_DEY = 6'd15;
  localparam logic [5:0] OP_INC = 6'd16;
  localparam logic [5:0] OP_DEC = 6'd17;
  localparam logic [5:0] OP_ORA = 6'd18;
  localparam logic [5:0] OP_AND = 6'd19;
  localparam logic [5:0] OP_EOR = 6'd20;
  localparam logic [5:0] OP_ADC = 6'd21;
  localparam logic [5:0] OP_SBC = 6'd22;
  localparam logic [5:0] OP_CMP = 6'd23;
  localparam logic [5:0] OP_CPX = 6'd24;
  localparam logic [5:0] OP_CPY = 6'd25;
  localparam logic [5:0] OP_BIT = 6'd26;
  localparam logic [5:0] OP_ASL = 6'd27;
  localparam logic [5:0] OP_LSR = 6'd28;
  localparam logic [5:0] OP_ROL = 6'd29;
  localparam logic [5:0] OP_ROR = 6'd30;
  localparam logic [5:0] OP_CLC = 6'd31;
  localparam logic [5:0] OP_SEC = 6'd32;
  localparam logic [5:0] OP_CLI = 6'd33;
  localparam logic [5:0] OP_SEI = 6'd34;
  localparam logic [5:0] OP_CLV = 6'd35;
  localparam logic [5:0] OP_CLD = 6'd36;
  localparam logic [5:0] OP_SED = 6'd37;
  localparam logic [5:0] OP_BPL = 6'd38;
  localparam logic [5:0] OP_BMI = 6'd39;
  localparam logic [5:0] OP_BVC = 6'd40;
  localparam logic [5:0] OP_BVS = 6'd41;
  localparam logic [5:0] OP_BCC = 6'd42;
  localparam logic [5:0] OP_BCS = 6'd43;
  localparam logic [5:0] OP_BNE = 6'd44;
  localparam logic [5:0] OP_BEQ = 6'd45;
  localparam logic [5:0] OP_PHA = 6'd46;
  localparam logic [5:0] OP_PHP = 6'd47;
  localparam logic [5:0] OP_PLA = 6'd48;
  localparam logic [5:0] OP_PLP = 6'd49;
  localparam logic [5:0] OP_ANC = 6'd50;
  localparam logic [5:0] OP_ALR = 6'd51;
  localparam logic [5:0] OP_ARR = 6'd52;
  localparam logic [5:0] OP_ATX = 6'd53;

  localparam logic [7:0] SP_RESET    = 8'hFD;
  localparam logic [7:0] FLAGS_RESET = 8'h24;
  localparam logic [7:0] ATX_MAGIC   = 8'hEE;

  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_I = 2;
  localparam int FLAG_D = 3;
  localparam int FLAG_B = 4;
  localparam int FLAG_U = 5;
  localparam int FLAG_V = 6;
  localparam int FLAG_N = 7;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  operand;
    logic [15:0] pc;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  data_out;
    logic        data_valid;
    logic [8:0]  stack_address;
    logic        branch_taken;
    logic [15:0] next_pc;
    logic [7:0]  acc;
    logic [7:0]  index_x;
    logic [7:0]  index_y;
    logic [7:0]  stack_ptr;
    logic [7:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] x;
    logic [7:0] y;
    logic [7:0] sp;
    logic [7:0] p;
  } arch_state_t;

endpackage

// ===== rtl/core/bcpu_if.sv =====
// ----------------------------------------------------------------------------
// bcpu_in_if / bcpu_out_if
// Valid/ready channels for operation and result transactions.
// ----------------------------------------------------------------------------
interface bcpu_in_if;
  logic              valid;
  logic              ready;
  bcpu_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface bcpu_out_if;
  logic               valid;
  logic               ready;
  bcpu_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/bcpu_alu.sv =====
// ----------------------------------------------------------------------------
// bcpu_alu
// Combinational execute logic: one operation on the register file.
// ----------------------------------------------------------------------------
module bcpu_alu (
  input  bcpu_pkg::in_item_t    item,
  input  bcpu_pkg::arch_state_t st,
  output bcpu_pkg::arch_state_t st_nxt,
  output bcpu_pkg::out_item_t   res
);

  logic [7:0] m;
  logic [7:0] p;
  logic       c_in;
  logic [8:0] sum;
  logic [7:0] add_m;
  logic [7:0] r;
  logic [8:0] cmp_d;
  logic [7:0] cmp_reg;
  logic [2:0] bsel;
  logic       bflag;
  logic [7:0] dout;
  logic       dvalid;
  logic       stack_op;
  logic [7:0] saddr_lo;
  logic       taken;
  logic [15:0] pc1;

  always_comb begin
    m        = item.operand;
    st_nxt   = st;
    p        = st.p;
    c_in     = st.p[bcpu_pkg::FLAG_C];
    dout     = 8'h00;
    dvalid   = 1'b0;
    stack_op = 1'b0;
    saddr_lo = st.sp;
    taken    = 1'b0;
    pc1      = item.pc + 16'd1;
    add_m    = (item.kind == bcpu_pkg::OP_SBC) ? ~m : m;
    sum      = {1'b0, st.a} + {1'b0, add_m} + {8'h00, c_in};
    r        = 8'h00;
    bsel     = 3'(item.kind - bcpu_pkg::OP_BPL);
    case (bsel[2:1])
      2'd0:    bflag = st.p[bcpu_pkg::FLAG_N];
      2'd1:    bflag = st.p[bcpu_pkg::FLAG_V];
      2'd2:    bflag = st.p[bcpu_pkg::FLAG_C];
      default: bflag = st.p[bcpu_pkg::FLAG_Z];
    endcase
    case (item.kind)
      bcpu_pkg::OP_CPX: cmp_reg = st.x;
      bcpu_pkg::OP_CPY: cmp_reg = st.y;
      default:          cmp_reg = st.a;
    endcase
    cmp_d = {1'b0, cmp_reg} - {1'b0, m};

    case (item.kind)
      bcpu_pkg::OP_LDA: r = m;
      bcpu_pkg::OP_LDX: r = m;
      bcpu_pkg::OP_LDY: r = m;
      bcpu_pkg::OP_TAX, bcpu_pkg::OP_TAY: r = st.a;
      bcpu_pkg::OP_TXA: r = st.x;
      bcpu_pkg::OP_TYA: r = st.y;
      bcpu_pkg::OP_TSX: r = st.sp;
      bcpu_pkg::OP_INX: r = st.x + 8'd1;
      bcpu_pkg::OP_INY: r = st.y + 8'd1;
      bcpu_pkg::OP_DEX: r = st.x - 8'd1;
      bcpu_pkg::OP_DEY: r = st.y - 8'd1;
      bcpu_pkg::OP_INC: r = m + 8'd1;
      bcpu_pkg::OP_DEC: r = m - 8'd1;
      bcpu_pkg::OP_ORA: r = st.a | m;
      bcpu_pkg::OP_AND, bcpu_pkg::OP_ANC: r = st.a & m;
      bcpu_pkg::OP_EOR: r = st.a ^ m;
      bcpu_pkg::OP_ADC, bcpu_pkg::OP_SBC: r = sum[7:0];
      bcpu_pkg::OP_ASL: r = {m[6:0], 1'b0};
      bcpu_pkg::OP_LSR: r = {1'b0, m[7:1]};
      bcpu_pkg::OP_ROL: r = {m[6:0], c_in};
      bcpu_pkg::OP_ROR: r = {c_in, m[7:1]};
      bcpu_pkg::OP_PLA: r = m;
      bcpu_pkg::OP_ALR: r = {1'b0, st.a[7:1] & m[7:1]};
      bcpu_pkg::OP_ARR: r = {c_in, st.a[7:1] & m[7:1]};
      bcpu_pkg::OP_ATX: r = (st.a | bcpu_pkg::ATX_MAGIC) & m;
      default: r = 8'h00;
    endcase

    case (item.kind)
      bcpu_pkg::OP_LDA, bcpu_pkg::OP_TXA, bcpu_pkg::OP_TYA, bcpu_pkg::OP_ORA,
      bcpu_pkg::OP_AND, bcpu_pkg::OP_EOR, bcpu_pkg::OP_ANC, bcpu_pkg::OP_ALR,
      bcpu_pkg::OP_ARR: begin
        st_nxt.a = r;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
        if (item.kind == bcpu_pkg::OP_ANC) p[bcpu_pkg::FLAG_C] = r[7];
        if (item.kind == bcpu_pkg::OP_ALR) p[bcpu_pkg::FLAG_C] = st.a[0] & m[0];
        if (item.kind == bcpu_pkg::OP_ARR) begin
          p[bcpu_pkg::FLAG_C] = r[6];
          p[bcpu_pkg::FLAG_V] = r[6] ^ r[5];
        end
      end
      bcpu_pkg::OP_LDX, bcpu_pkg::OP_TAX, bcpu_pkg::OP_TSX, bcpu_pkg::OP_INX,
      bcpu_pkg::OP_DEX: begin
        st_nxt.x = r;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
      end
      bcpu_pkg::OP_LDY, bcpu_pkg::OP_TAY, bcpu_pkg::OP_INY, bcpu_pkg::OP_DEY: begin
        st_nxt.y = r;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
      end
      bcpu_pkg::OP_STA: begin dout = st.a; dvalid = 1'b1; end
      bcpu_pkg::OP_STX: begin dout = st.x; dvalid = 1'b1; end
      bcpu_pkg::OP_STY: begin dout = st.y; dvalid = 1'b1; end
      bcpu_pkg::OP_TXS: st_nxt.sp = st.x;
      bcpu_pkg::OP_INC, bcpu_pkg::OP_DEC, bcpu_pkg::OP_ASL, bcpu_pkg::OP_LSR,
      bcpu_pkg::OP_ROL, bcpu_pkg::OP_ROR: begin
        dout = r;
        dvalid = 1'b1;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
        if (item.kind == bcpu_pkg::OP_ASL || item.kind == bcpu_pkg::OP_ROL)
          p[bcpu_pkg::FLAG_C] = m[7];
        if (item.kind == bcpu_pkg::OP_LSR || item.kind == bcpu_pkg::OP_ROR)
          p[bcpu_pkg::FLAG_C] = m[0];
      end
      bcpu_pkg::OP_ADC, bcpu_pkg::OP_SBC: begin
        st_nxt.a = r;
        p[bcpu_pkg::FLAG_C] = sum[8];
        p[bcpu_pkg::FLAG_V] = ~(st.a[7] ^ add_m[7]) & (st.a[7] ^ r[7]);
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
      end
      bcpu_pkg::OP_CMP, bcpu_pkg::OP_CPX, bcpu_pkg::OP_CPY: begin
        p[bcpu_pkg::FLAG_C] = ~cmp_d[8];
        p[bcpu_pkg::FLAG_Z] = (cmp_d[7:0] == 8'h00);
        p[bcpu_pkg::FLAG_N] = cmp_d[7];
      end
      bcpu_pkg::OP_BIT: begin
        p[bcpu_pkg::FLAG_V] = m[6];
        p[bcpu_pkg::FLAG_N] = m[7];
        p[bcpu_pkg::FLAG_Z] = ((m & st.a) == 8'h00);
      end
      bcpu_pkg::OP_CLC: p[bcpu_pkg::FLAG_C] = 1'b0;
      bcpu_pkg::OP_SEC: p[bcpu_pkg::FLAG_C] = 1'b1;
      bcpu_pkg::OP_CLI: p[bcpu_pkg::FLAG_I] = 1'b0;
      bcpu_pkg::OP_SEI: p[bcpu_pkg::FLAG_I] = 1'b1;
      bcpu_pkg::OP_CLV: p[bcpu_pkg::FLAG_V] = 1'b0;
      bcpu_pkg::OP_CLD: p[bcpu_pkg::FLAG_D] = 1'b0;
      bcpu_pkg::OP_SED: p[bcpu_pkg::FLAG_D] = 1'b1;
      bcpu_pkg::OP_BPL, bcpu_pkg::OP_BMI, bcpu_pkg::OP_BVC, bcpu_pkg::OP_BVS,
      bcpu_pkg::OP_BCC, bcpu_pkg::OP_BCS, bcpu_pkg::OP_BNE, bcpu_pkg::OP_BEQ:
        taken = bsel[0] ? bflag : ~bflag;
      bcpu_pkg::OP_PHA, bcpu_pkg::OP_PHP: begin
        stack_op = 1'b1;
        dvalid   = 1'b1;
        dout     = (item.kind == bcpu_pkg::OP_PHA) ? st.a : (st.p | 8'h30);
        st_nxt.sp = st.sp - 8'd1;
      end
      bcpu_pkg::OP_PLA: begin
        st_nxt.sp = st.sp + 8'd1;
        stack_op  = 1'b1;
        st_nxt.a  = r;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
      end
      bcpu_pkg::OP_PLP: begin
        st_nxt.sp = st.sp + 8'd1;
        stack_op  = 1'b1;
        p = m;
      end
      bcpu_pkg::OP_ATX: begin
        st_nxt.a = r;
        st_nxt.x = r;
        p[bcpu_pkg::FLAG_Z] = (r == 8'h00);
        p[bcpu_pkg::FLAG_N] = r[7];
      end
      default: ;
    endcase

    p[bcpu_pkg::FLAG_U] = 1'b1;
    p[bcpu_pkg::FLAG_B] = 1'b0;
    st_nxt.p = p;

    // Push addresses the old SP; pull and non-stack ops show the new SP.
    if (stack_op && (item.kind == bcpu_pkg::OP_PHA || item.kind == bcpu_pkg::OP_PHP))
      saddr_lo = st.sp;
    else
      saddr_lo = st_nxt.sp;

    res.data_out      = dout;
    res.data_valid    = dvalid;
    res.stack_address = {1'b1, saddr_lo};
    res.branch_taken  = taken;
    res.next_pc       = taken ? (pc1 + {{8{m[7]}}, m}) : pc1;
    res.acc           = st_nxt.a;
    res.index_x       = st_nxt.x;
    res.index_y       = st_nxt.y;
    res.stack_ptr     = st_nxt.sp;
    res.status        = st_nxt.p;
  end

endmodule

// ===== rtl/core/byte_cpu_execute_unit.sv =====
// ----------------------------------------------------------------------------
// byte_cpu_execute_unit
// Execute stage of a 6502-style byte CPU with its register file.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  in_     | sink      | kind, operand, pc
//  out_    | source    | data_out .. status (registers after the operation)
//
//  One transaction per cycle unless out_ stalls: the operation executes in
//  the ALU logic between the architectural registers and the result register.
//  Reset clears A, X, Y, sets SP to 0xFD and flags to 0x24; no result pending.
//  A stall on out_ holds the result; in_ stays ready while the result
//  register is empty or being drained in the same cycle.
module byte_cpu_execute_unit (
  input logic   clk,
  input logic   rst_n,
  bcpu_in_if.sink    in_ch,
  bcpu_out_if.source out_ch
);

  bcpu_pkg::arch_state_t st_r;
  bcpu_pkg::arch_state_t st_nxt;
  bcpu_pkg::out_item_t   res_r;
  bcpu_pkg::out_item_t   res_nxt;
  logic                  res_vld_r;
  logic                  take;

  // Advance whenever the result slot is free or drains this cycle.
  assign in_ch.ready = ~res_vld_r | out_ch.ready;
  assign take        = in_ch.valid & in_ch.ready;

  bcpu_alu u_alu (
    .item   (in_ch.payload),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.a    <= 8'h00;
      st_r.x    <= 8'h00;
      st_r.y    <= 8'h00;
      st_r.sp   <= bcpu_pkg::SP_RESET;
      st_r.p    <= bcpu_pkg::FLAGS_RESET;
      res_vld_r <= 1'b0;
    end else begin
      if (take) begin
        st_r      <= st_nxt;
        res_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        res_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) res_r <= res_nxt;
  end

  assign out_ch.valid   = res_vld_r;
  assign out_ch.payload = res_r;

endmodule
